>>> rtl/dfa_word_acceptor_defines.svh
// ----------------------------------------------------------------------------
// dfa_word_acceptor_defines
// assertion macros shared by the dfa word acceptor modules
// ----------------------------------------------------------------------------
`ifndef DFA_WORD_ACCEPTOR_DEFINES_SVH
`define DFA_WORD_ACCEPTOR_DEFINES_SVH

`ifndef SYNTHESIS

// checked outside reset only
`define DWA_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("dwa assertion failed");

// checked at every edge, reset included
`define DWA_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
        else $error("dwa assertion failed");

`else

`define DWA_ASSERT(lbl, clk_s, rst_s, prop)
`define DWA_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

>>> rtl/dwa_pkg.sv
// ----------------------------------------------------------------------------
// dwa_pkg
// shared types and constants of the dfa word acceptor
// ----------------------------------------------------------------------------
package dwa_pkg;

    localparam int STATE_W     = 4;   // width of a state field
    localparam int SYM_W       = 8;   // width of the symbol port
    localparam int MASK_W      = 16;  // width of the accepting-state mask
    localparam int CFG_IDX_W   = 1;   // register index width
    localparam int CFG_DATA_W  = 16;  // widest register
    localparam int QUEUE_DEPTH = 2;

    // register indices
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

    // item kind, coded as the req_type field
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_FEED = 1'b1
    } dwa_op_t;

    // classified item passed from front to back
    typedef struct packed {
        dwa_op_t            kind;
        logic [STATE_W-1:0] from_state;
        logic [STATE_W-1:0] to_state;
        logic [SYM_W-1:0]   sym;
        logic               last;
    } dwa_item_t;

    // queue status seen by the back and by the port's busy logic
    typedef struct packed {
        logic empty;
        logic full;
    } dwa_qstat_t;

    // one transition table entry
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] nxt;
    } dwa_entry_t;

endpackage

>>> rtl/dwa_front.sv
// ----------------------------------------------------------------------------
// dwa_front
// takes items at the command port, drops out-of-range loads, queues the rest
// ----------------------------------------------------------------------------
module dwa_front
    import dwa_pkg::*;
#(
    parameter int NUM_STATES = 16
)
(
    input  logic               start,
    input  logic               busy,
    input  logic               req_type,
    input  logic [STATE_W-1:0] from_state,
    input  logic [SYM_W-1:0]   symbol,
    input  logic [STATE_W-1:0] to_state,
    input  logic               last_symbol,
    output logic               push,
    output dwa_item_t          item
);

    logic    load_ok;
    dwa_op_t kind;

    assign kind    = dwa_op_t'(req_type);
    assign load_ok = (32'(from_state) < NUM_STATES) && (32'(to_state) < NUM_STATES);

    always_comb
    begin
        item.kind       = kind;
        item.from_state = from_state;
        item.to_state   = to_state;
        item.sym        = symbol;
        item.last       = last_symbol;
        // a load naming a state beyond the table is taken and forgotten
        push = start && !busy && ((kind == OP_FEED) || load_ok);
    end

endmodule

>>> rtl/dwa_queue.sv
// ----------------------------------------------------------------------------
// dwa_queue
// two-entry queue between the front and the back
// ----------------------------------------------------------------------------
`include "dfa_word_acceptor_defines.svh"

module dwa_queue
    import dwa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  dwa_item_t  push_item,
    input  logic       pop,
    output dwa_item_t  pop_item,
    output dwa_qstat_t stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dwa_item_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item   = slot_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    `DWA_ASSERT(a_q_no_overflow, clk, rst_n, push |-> (!stat.full || pop))
    `DWA_ASSERT(a_q_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

>>> rtl/dwa_back.sv
// ----------------------------------------------------------------------------
// dwa_back
// transition table and word stepping engine
// ----------------------------------------------------------------------------
`include "dfa_word_acceptor_defines.svh"

module dwa_back
    import dwa_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dwa_item_t          q_item,
    input  dwa_qstat_t         q_stat,
    input  logic [STATE_W-1:0] start_state,
    input  logic [MASK_W-1:0]  accept_mask,
    output logic               pop,
    output logic               clearing,
    output logic               done,
    output logic               accepted
);

    localparam int IDX_SB = $clog2(NUM_STATES);
    localparam int ADDR_W = IDX_SB + SYMBOL_BITS;
    localparam int DEPTH  = NUM_STATES * (2 ** SYMBOL_BITS);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_WAIT  = 3'b100
    } back_state_t;

    back_state_t        state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [STATE_W-1:0] cur_reg, cur_next;
    logic               dead_reg, dead_next;
    logic               started_reg, started_next;
    logic               last_reg, last_next;
    logic               done_reg, done_next;
    logic               acc_reg, acc_next;

    dwa_entry_t         table_mem [DEPTH];
    dwa_entry_t         rd_data_reg;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    dwa_entry_t         mem_wdata;

    logic [STATE_W-1:0] eff_state;
    logic               eff_dead;
    logic               start_ok;

    assign start_ok  = (32'(start_state) < NUM_STATES);
    assign eff_state = started_reg ? cur_reg : start_state;
    assign eff_dead  = started_reg ? dead_reg : !start_ok;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cur_next      = cur_reg;
        dead_next     = dead_reg;
        started_next  = started_reg;
        last_next     = last_reg;
        done_next     = 1'b0;
        acc_next      = acc_reg;
        pop           = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_raddr     = {IDX_SB'(32'(eff_state)), q_item.sym[SYMBOL_BITS-1:0]};
        mem_wdata     = '0;

        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    if (q_item.kind == OP_LOAD)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {IDX_SB'(32'(q_item.from_state)),
                                     q_item.sym[SYMBOL_BITS-1:0]};
                        mem_wdata = '{valid: 1'b1, nxt: q_item.to_state};
                    end
                    else
                    begin
                        started_next = 1'b1;
                        cur_next     = eff_state;
                        dead_next    = eff_dead;
                        if (eff_dead)
                        begin
                            // dead word: no lookup, answer at once on its last symbol
                            if (q_item.last)
                            begin
                                done_next    = 1'b1;
                                acc_next     = 1'b0;
                                started_next = 1'b0;
                            end
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            last_next  = q_item.last;
                            state_next = B_WAIT;
                        end
                    end
                end
            end
            B_WAIT:
            begin
                if (rd_data_reg.valid)
                begin
                    cur_next = rd_data_reg.nxt;
                end
                else
                begin
                    dead_next = 1'b1;
                end
                if (last_reg)
                begin
                    done_next    = 1'b1;
                    acc_next     = rd_data_reg.valid && accept_mask[rd_data_reg.nxt];
                    started_next = 1'b0;
                end
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            cur_reg      <= '0;
            dead_reg     <= 1'b0;
            started_reg  <= 1'b0;
            last_reg     <= 1'b0;
            done_reg     <= 1'b0;
            acc_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cur_reg      <= cur_next;
            dead_reg     <= dead_next;
            started_reg  <= started_next;
            last_reg     <= last_next;
            done_reg     <= done_next;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_raddr];
        end
    end

    assign clearing = (state_reg == B_CLEAR);
    assign done     = done_reg;
    assign accepted = acc_reg;

    `DWA_ASSERT(a_clear_no_pop, clk, rst_n, clearing |-> (!pop && !done_reg))
    `DWA_ASSERT(a_wait_one_cycle, clk, rst_n, (state_reg == B_WAIT) |=> (state_reg == B_IDLE))
    `DWA_ASSERT_ALWAYS(a_accept_needs_done, clk, (done_reg && acc_reg) |-> !dead_reg)

endmodule

>>> rtl/dfa_word_acceptor.sv
// ----------------------------------------------------------------------------
// dfa_word_acceptor
// table-driven deterministic finite automaton that accepts or rejects words
// ----------------------------------------------------------------------------
// usage
//   command port: an item is taken at a rising edge with start high and busy
//   low. req_type selects a transition load (from_state, symbol, to_state)
//   or a word symbol (symbol, last_symbol)
//   result: done is high for one cycle after the last symbol of a word,
//   with accepted showing whether the word ended in an accepting state.
//   the receiver cannot stall; every result is taken the cycle it shows
//   config port: cfg_we, cfg_index, cfg_wdata write start_state (index 0)
//   and accept_mask (index 1); the user must write only while the block is
//   idle, as the block itself does not enforce it
//   timing: a live symbol is read from the table in B_IDLE and applied in
//   B_WAIT, set by the registered table read port; a load or a dead-word
//   symbol is done in B_IDLE alone. done is registered from B_WAIT, or from
//   B_IDLE for a dead word; items already queued go through the back end
//   first. a two-item queue lets the port run ahead
//   reset: after rst_n the table is swept to invalid, one entry a cycle,
//   all NUM_STATES * 2**SYMBOL_BITS entries (4096 by default); busy stays
//   high meanwhile, config writes are taken as usual
// ----------------------------------------------------------------------------
module dfa_word_acceptor
    import dwa_pkg::*;
#(
    parameter int NUM_STATES  = 16,
    parameter int SYMBOL_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command port
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [STATE_W-1:0]    from_state,
    input  logic [SYM_W-1:0]      symbol,
    input  logic [STATE_W-1:0]    to_state,
    input  logic                  last_symbol,
    // result port
    output logic                  done,
    output logic                  accepted,
    // configuration port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic [STATE_W-1:0] start_state_reg, start_state_next;
    logic [MASK_W-1:0]  accept_mask_reg, accept_mask_next;

    // front to queue
    logic       push;
    dwa_item_t  push_item;

    // queue to back
    logic       pop;
    dwa_item_t  pop_item;
    dwa_qstat_t q_stat;

    logic       clearing;

    // register decoder
    always_comb
    begin
        start_state_next = start_state_reg;
        accept_mask_next = accept_mask_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_STATE: start_state_next = cfg_wdata[STATE_W-1:0];
                CFG_ACCEPT_MASK: accept_mask_next = cfg_wdata[MASK_W-1:0];
                default:
                begin
                    start_state_next = start_state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            accept_mask_reg <= '0;
        end
        else
        begin
            start_state_reg <= start_state_next;
            accept_mask_reg <= accept_mask_next;
        end
    end

    // port holds off while the table is being swept or the queue is full
    assign busy = clearing || q_stat.full;

    // front: takes and classifies items
    dwa_front #(
        .NUM_STATES (NUM_STATES)
    ) u_front (
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .from_state  (from_state),
        .symbol      (symbol),
        .to_state    (to_state),
        .last_symbol (last_symbol),
        .push        (push),
        .item        (push_item)
    );

    // short queue so the port and the engine stall apart
    dwa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    // back: table memory and automaton stepping
    dwa_back #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (pop_item),
        .q_stat      (q_stat),
        .start_state (start_state_reg),
        .accept_mask (accept_mask_reg),
        .pop         (pop),
        .clearing    (clearing),
        .done        (done),
        .accepted    (accepted)
    );

endmodule

>>> verif/tb_dfa_word_acceptor.sv
// ----------------------------------------------------------------------------
// tb_dfa_word_acceptor
// self-checking bench for the table-driven dfa word acceptor
// ----------------------------------------------------------------------------
// a directed run over the empty table, entry loads and overwrites, dead words
// and start-state changes inside a word is followed by random phases. each
// phase sets the registers, fills the table over a small symbol alphabet and
// then walks words that mostly follow loaded transitions, with stray symbols
// and loads mixed in. a local copy of the automaton predicts every verdict
// ----------------------------------------------------------------------------
module tb_dfa_word_acceptor;
    import dwa_pkg::*;

    localparam int NSTATES       = 16;
    localparam int SBITS         = 8;
    localparam int TBL_DEPTH     = NSTATES << SBITS;
    localparam int RESET_HOLD    = 12;
    localparam int SETTLE_CYCLES = 16;      // queue of two plus back end and done delay
    localparam int ITEM_TARGET   = 1550;
    localparam int CYCLE_LIMIT   = 250000;  // sweep plus worst-case gaps, several times over

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic                  req_type    = 1'b0;
    logic [STATE_W-1:0]    from_state  = '0;
    logic [SYM_W-1:0]      symbol      = '0;
    logic [STATE_W-1:0]    to_state    = '0;
    logic                  last_symbol = 1'b0;
    logic                  done;
    logic                  accepted;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

    dfa_word_acceptor dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .from_state  (from_state),
        .symbol      (symbol),
        .to_state    (to_state),
        .last_symbol (last_symbol),
        .done        (done),
        .accepted    (accepted),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // local automaton: transition table, word walk and register copies
    // ------------------------------------------------------------------------
    dwa_entry_t         trans_tbl [TBL_DEPTH];
    logic [STATE_W-1:0] walk_state;
    logic               walk_dead;
    logic               walk_open;   // a word has had its first symbol
    logic [STATE_W-1:0] cfg_start;
    logic [MASK_W-1:0]  cfg_mask;

    // verdicts of finished words, oldest first
    bit expected_verdicts [$];

    int unsigned loads_sent       = 0;
    int unsigned feeds_sent       = 0;
    int unsigned words_sent       = 0;
    int unsigned verdicts_checked = 0;
    int unsigned cfg_writes       = 0;
    int unsigned failures         = 0;
    int unsigned cycles           = 0;

    // sender idles between items unless a phase turns this on
    bit idle_off = 1'b0;

    task automatic clear_automaton();
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            trans_tbl[i] = '0;
        end
        walk_state = '0;
        walk_dead  = 1'b0;
        walk_open  = 1'b0;
        cfg_start  = '0;
        cfg_mask   = '0;
    endtask

    // advance the local automaton by one accepted item
    task automatic predict_item(input dwa_item_t it);
        dwa_entry_t ent;
        bit         verdict;
        if (it.kind == OP_LOAD)
        begin
            // every 4-bit state is in range with 16 states, so each load lands;
            // last_symbol is ignored and the word in progress is left alone
            ent.valid = 1'b1;
            ent.nxt   = it.to_state;
            trans_tbl[{it.from_state, it.sym}] = ent;
        end
        else
        begin
            // start state taken only at the first symbol of a word
            if (!walk_open)
            begin
                walk_open  = 1'b1;
                walk_state = cfg_start;
                walk_dead  = 1'b0;
            end
            // a missing transition kills the word until its last symbol
            if (!walk_dead)
            begin
                ent = trans_tbl[{walk_state, it.sym}];
                if (ent.valid)
                    walk_state = ent.nxt;
                else
                    walk_dead = 1'b1;
            end
            // accepting mask taken at the last symbol
            if (it.last)
            begin
                verdict = !walk_dead && cfg_mask[walk_state];
                expected_verdicts = {expected_verdicts, verdict};
                walk_open = 1'b0;
                words_sent++;
            end
        end
    endtask

    function automatic dwa_item_t load_item(input logic [STATE_W-1:0] src,
                                            input logic [SYM_W-1:0] sym,
                                            input logic [STATE_W-1:0] dst,
                                            input logic lst);
        dwa_item_t it;
        it.kind       = OP_LOAD;
        it.from_state = src;
        it.sym        = sym;
        it.to_state   = dst;
        it.last       = lst;
        return it;
    endfunction

    // state fields of a symbol item carry noise, the block must ignore them
    function automatic dwa_item_t feed_item(input logic [SYM_W-1:0] sym, input logic lst);
        dwa_item_t it;
        it.kind       = OP_FEED;
        it.from_state = STATE_W'($urandom_range(0, 15));
        it.sym        = sym;
        it.to_state   = STATE_W'($urandom_range(0, 15));
        it.last       = lst;
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // command port: called and returning at a rising edge
    // start is only lowered when a gap follows, so it never drops and rises
    // within one step; busy is sampled mid-cycle, clear of the edge
    // ------------------------------------------------------------------------
    task automatic send_item(input dwa_item_t it);
        int gap;
        bit taken;
        gap = idle_off ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= it.kind;
        from_state  <= it.from_state;
        symbol      <= it.sym;
        to_state    <= it.to_state;
        last_symbol <= it.last;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (busy === 1'b0);
            @(posedge clk);
        end
        predict_item(it);
        if (it.kind == OP_LOAD)
            loads_sent++;
        else
            feeds_sent++;
    endtask

    // hold the port, wait out every pending verdict, then let the back end
    // finish loads and inner symbols that give no result
    task automatic settle();
        start <= 1'b0;
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the enable is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        if (idx == CFG_START_STATE)
            cfg_start = data[STATE_W-1:0];
        else
            cfg_mask = data[MASK_W-1:0];
        cfg_writes++;
    endtask

    // both registers back to back, then the enable drops
    task automatic write_config(input logic [CFG_DATA_W-1:0] start_data,
                                input logic [CFG_DATA_W-1:0] mask_data);
        write_reg(CFG_START_STATE, start_data);
        write_reg(CFG_ACCEPT_MASK, mask_data);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result checker: done is looked at mid-cycle, one verdict per strobe
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        bit want;
        if (rst_n && done !== 1'b0)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("accepted: no word pending, expected none actual %0b", accepted);
                failures++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (accepted !== want)
                begin
                    $error("accepted mismatch: expected %0b actual %0b", want, accepted);
                    failures++;
                end
                verdicts_checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("dfa_word_acceptor verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------

    // registers and table at their reset values: every word dies at once
    task automatic test_empty_table();
        send_item(feed_item(8'h3C, 1'b1));
        settle();
    endtask

    // loads, walks to an accepting state, dead words, overwrite, load mid-word
    task automatic test_table_walk();
        write_config(16'h0000, 16'h8000);
        // last_symbol on a load is ignored
        send_item(load_item(4'h0, 8'h00, 4'hF, 1'b1));
        send_item(load_item(4'hF, 8'hFF, 4'hF, 1'b0));
        // 0 -00-> 15 -FF-> 15, state 15 accepting
        send_item(feed_item(8'h00, 1'b0));
        send_item(feed_item(8'hFF, 1'b1));
        // no entry for (0, FF): one-symbol dead word
        send_item(feed_item(8'hFF, 1'b1));
        // word dies in the middle and stays dead through a valid symbol
        send_item(feed_item(8'h00, 1'b0));
        send_item(feed_item(8'h55, 1'b0));
        send_item(feed_item(8'hFF, 1'b1));
        // overwrite (0, 00) so the word ends in a rejecting state
        send_item(load_item(4'h0, 8'h00, 4'h3, 1'b0));
        send_item(feed_item(8'h00, 1'b1));
        settle();
        // top start state, every state accepting
        write_config(16'h000F, 16'hFFFF);
        send_item(feed_item(8'hFF, 1'b1));
        // a load inside a word changes the path of that same word
        send_item(feed_item(8'hFF, 1'b0));
        send_item(load_item(4'hF, 8'hFF, 4'h0, 1'b1));
        send_item(feed_item(8'hFF, 1'b1));
        settle();
    endtask

    // start state is taken at the first symbol, the mask at the last
    task automatic test_start_change_mid_word();
        write_config(16'h0000, 16'h0008);
        send_item(load_item(4'h3, 8'hAA, 4'h0, 1'b0));
        send_item(feed_item(8'h00, 1'b0));        // 0 -> 3
        settle();
        write_config(16'h000F, 16'h0001);
        send_item(feed_item(8'hAA, 1'b1));        // 3 -> 0, accepted under new mask
        settle();
    endtask

    // ------------------------------------------------------------------------
    // random phases
    // ------------------------------------------------------------------------

    // pick a symbol with a loaded transition from where the word stands, if there is one
    function automatic logic [SYM_W-1:0] walk_symbol(input logic [SYM_W-1:0] alpha [8]);
        logic [STATE_W-1:0] st;
        int                 off;
        st  = walk_open ? walk_state : cfg_start;
        off = $urandom_range(0, 7);
        for (int i = 0; i < 8; i++)
        begin
            if (trans_tbl[{st, alpha[(off + i) % 8]}].valid)
                return alpha[(off + i) % 8];
        end
        return alpha[off];
    endfunction

    task automatic run_word(input logic [SYM_W-1:0] alpha [8]);
        int               len;
        logic [SYM_W-1:0] sym;
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
        begin
            // stray load inside the word, sometimes on its own path
            if ($urandom_range(0, 9) == 0)
                send_item(load_item(STATE_W'($urandom_range(0, 15)),
                                    alpha[$urandom_range(0, 7)],
                                    STATE_W'($urandom_range(0, 15)),
                                    1'($urandom_range(0, 1))));
            // most symbols follow the table, a few are arbitrary bytes
            if ($urandom_range(0, 7) == 0)
                sym = SYM_W'($urandom_range(0, 255));
            else
                sym = walk_symbol(alpha);
            send_item(feed_item(sym, k == len - 1));
        end
    endtask

    task automatic test_random_words();
        logic [SYM_W-1:0]   alpha [8];
        logic [STATE_W-1:0] st;
        logic [MASK_W-1:0]  msk;
        int                 ph;
        ph = 0;
        while (loads_sent + feeds_sent < ITEM_TARGET)
        begin
            settle();
            // extremes first, then random settings
            case (ph)
                0:       begin st = 4'h0; msk = 16'hFFFF; end
                1:       begin st = 4'hF; msk = 16'h0000; end
                2:       begin st = 4'hF; msk = 16'h8000; end
                3:       begin st = 4'h0; msk = 16'h0001; end
                default:
                begin
                    st  = STATE_W'($urandom_range(0, 15));
                    msk = MASK_W'($urandom_range(0, 16'hFFFF));
                end
            endcase
            // upper bits of the start write carry noise
            write_config({12'($urandom_range(0, 12'hFFF)), st}, msk);
            idle_off = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 8; i++)
            begin
                alpha[i] = SYM_W'($urandom_range(0, 255));
            end
            // two transition loads out of every state over this phase's alphabet
            for (int s = 0; s < NSTATES; s++)
            begin
                repeat (2)
                    send_item(load_item(STATE_W'(s), alpha[$urandom_range(0, 7)],
                                        STATE_W'($urandom_range(0, 15)),
                                        1'($urandom_range(0, 1))));
            end
            repeat ($urandom_range(12, 24)) run_word(alpha);
            ph++;
        end
        idle_off = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clear_automaton();
        repeat (RESET_HOLD) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the block sweeps its table after reset; the first item waits on busy
        test_empty_table();
        test_table_walk();
        test_start_change_mid_word();
        test_random_words();

        settle();
        $display("sent %0d items: %0d loads, %0d symbols in %0d words",
                 loads_sent + feeds_sent, loads_sent, feeds_sent, words_sent);
        $display("checked %0d verdicts over %0d register writes", verdicts_checked, cfg_writes);
        if (failures == 0)
            $display("dfa_word_acceptor verification clean");
        else
            $display("dfa_word_acceptor verification failed");
        $finish;
    end

endmodule
